/* hdl/ffha_pkg.sv */
// shared types and constants of the first-fit heap allocator
// no dependencies; imported by every allocator module
`default_nettype none

package ffha_pkg;

   localparam int DATA_W    = 32;
   localparam int SUM_W     = DATA_W + 2;
   localparam int IDX_OUT_W = 6;
   localparam int STATUS_W  = 2;

   localparam logic [DATA_W-1:0] HEAP_LIMIT_RESET = 32'd65536;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_REUSED  = 2'd0,
      ST_DONE    = 2'd1,
      ST_NOMEM   = 2'd2,
      ST_INVALID = 2'd3
   } status_type;

   // one table entry: header offset, payload size, free mark
   typedef struct packed {
      logic [DATA_W-1:0] blk_start;
      logic [DATA_W-1:0] blk_size;
      logic              blk_free;
   } entry_type;

   // operands of the shared add/compare unit
   typedef struct packed {
      logic [DATA_W-1:0] add_a;
      logic [DATA_W-1:0] add_b;
      logic [SUM_W-1:0]  cmp_a;
      logic [SUM_W-1:0]  cmp_b;
   } unit_req_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             ge;
   } unit_rsp_type;

   typedef struct packed {
      status_type           status;
      logic [IDX_OUT_W-1:0] index;
      logic [DATA_W-1:0]    addr;
      logic [DATA_W-1:0]    size;
   } result_type;

   localparam result_type RESULT_INVALID = '{status: ST_INVALID, index: '0,
                                             addr: '0, size: '0};
   localparam result_type RESULT_NOMEM   = '{status: ST_NOMEM, index: '0,
                                             addr: '0, size: '0};

endpackage

`default_nettype wire

/* hdl/ffha_unit.sv */
// shared add/compare unit: a + b + header and an unsigned compare
// depends on ffha_pkg
`default_nettype none

module ffha_unit #(
   parameter int HEADER_BYTES = 16
) (
   input  ffha_pkg::unit_req_type unit_req,
   output ffha_pkg::unit_rsp_type unit_rsp
);
   import ffha_pkg::*;

   always_comb begin
      unit_rsp.sum = {2'b00, unit_req.add_a} + {2'b00, unit_req.add_b}
                     + SUM_W'(HEADER_BYTES);
      unit_rsp.ge  = (unit_req.cmp_a >= unit_req.cmp_b);
   end

endmodule

`default_nettype wire

/* hdl/ffha_table.sv */
// block table memory: one write port, one registered read port
// depends on ffha_pkg
`default_nettype none

module ffha_table #(
   parameter int MAX_BLOCKS = 64
) (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire [$clog2(MAX_BLOCKS)-1:0] wr_addr,
   input  ffha_pkg::entry_type          wr_data,
   input  wire                          rd_en,
   input  wire [$clog2(MAX_BLOCKS)-1:0] rd_addr,
   output ffha_pkg::entry_type          rd_data
);
   import ffha_pkg::*;

   entry_type entry_mem [MAX_BLOCKS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/ffha_seq.sv */
// allocator sequencer: first-fit scan, heap growth and free handling
// depends on ffha_pkg, ffha_unit, ffha_table
`default_nettype none

module ffha_seq #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 16
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   output logic                                    req_stall,
   input  wire                                     req_opcode,
   input  wire [ffha_pkg::DATA_W-1:0]              req_size,
   input  wire [ffha_pkg::IDX_OUT_W-1:0]           req_block_index,
   input  wire [ffha_pkg::DATA_W-1:0]              heap_limit,
   output logic                                    res_valid,
   input  wire                                     res_take,
   output ffha_pkg::result_type                    res_data
);
   import ffha_pkg::*;

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int CMP_W = (CNT_W > IDX_OUT_W) ? CNT_W : IDX_OUT_W;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_SCAN     = 6'b000010,
      S_GROW_ADD = 6'b000100,
      S_GROW_CHK = 6'b001000,
      S_FREE     = 6'b010000,
      S_DONE     = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] heap_top_ff, heap_top_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [SUM_W-1:0]  end_ff, end_in;
   logic [DATA_W-1:0] want_ff, want_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   result_type        res_ff, res_in;

   logic              tbl_wr_en, tbl_rd_en;
   logic [IDX_W-1:0]  tbl_wr_addr, tbl_rd_addr;
   entry_type         tbl_wr_data, tbl_rd_data;
   unit_req_type      unit_req;
   unit_rsp_type      unit_rsp;

   logic [CMP_W-1:0]  req_idx_wide, rd_idx_wide, idx_wide, cnt_wide;
   logic              free_ok, grow_ok;

   ffha_unit #(
      .HEADER_BYTES(HEADER_BYTES)
   ) u_unit (
      .unit_req(unit_req),
      .unit_rsp(unit_rsp)
   );

   ffha_table #(
      .MAX_BLOCKS(MAX_BLOCKS)
   ) u_table (
      .clock  (clock),
      .wr_en  (tbl_wr_en),
      .wr_addr(tbl_wr_addr),
      .wr_data(tbl_wr_data),
      .rd_en  (tbl_rd_en),
      .rd_addr(tbl_rd_addr),
      .rd_data(tbl_rd_data)
   );

   assign req_idx_wide = CMP_W'(req_block_index);
   assign rd_idx_wide  = CMP_W'(rd_idx_ff);
   assign idx_wide     = CMP_W'(idx_ff);
   assign cnt_wide     = CMP_W'(count_ff);
   assign free_ok      = (req_idx_wide < cnt_wide);
   assign grow_ok      = unit_rsp.ge && (count_ff != CNT_W'(MAX_BLOCKS));

   assign req_stall = (state_ff != S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res_data  = res_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      heap_top_in = heap_top_ff;
      scan_in     = scan_ff;
      rd_vld_in   = 1'b0;
      rd_idx_in   = rd_idx_ff;
      end_in      = end_ff;
      want_in     = want_ff;
      idx_in      = idx_ff;
      res_in      = res_ff;
      tbl_rd_en   = 1'b0;
      tbl_rd_addr = rd_idx_ff;
      tbl_wr_en   = 1'b0;
      tbl_wr_addr = idx_ff;
      tbl_wr_data = '0;
      unit_req    = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               want_in = req_size;
               idx_in  = req_idx_wide[IDX_W-1:0];
               scan_in = '0;
               if (opcode_type'(req_opcode) == OP_FREE) begin
                  if (free_ok) begin
                     tbl_rd_en   = 1'b1;
                     tbl_rd_addr = req_idx_wide[IDX_W-1:0];
                     state_in    = S_FREE;
                  end else begin
                     res_in   = RESULT_INVALID;
                     state_in = S_DONE;
                  end
               end else if (req_size == '0) begin
                  res_in   = RESULT_INVALID;
                  state_in = S_DONE;
               end else if (count_ff == '0) begin
                  state_in = S_GROW_ADD;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // read issue and check of the previous read overlap
            unit_req.add_a = tbl_rd_data.blk_start;
            unit_req.cmp_a = {2'b00, tbl_rd_data.blk_size};
            unit_req.cmp_b = {2'b00, want_ff};
            if (scan_ff < count_ff) begin
               tbl_rd_en   = 1'b1;
               tbl_rd_addr = scan_ff[IDX_W-1:0];
               scan_in     = scan_ff + CNT_W'(1);
               rd_vld_in   = 1'b1;
               rd_idx_in   = scan_ff[IDX_W-1:0];
            end
            if (rd_vld_ff) begin
               if (tbl_rd_data.blk_free && unit_rsp.ge) begin
                  tbl_wr_en   = 1'b1;
                  tbl_wr_addr = rd_idx_ff;
                  tbl_wr_data = '{blk_start: tbl_rd_data.blk_start,
                                  blk_size: tbl_rd_data.blk_size, blk_free: 1'b0};
                  res_in      = '{status: ST_REUSED, index: rd_idx_wide[IDX_OUT_W-1:0],
                                  addr: unit_rsp.sum[DATA_W-1:0],
                                  size: tbl_rd_data.blk_size};
                  state_in    = S_DONE;
               end else if ((CNT_W'(rd_idx_ff) + CNT_W'(1)) == count_ff) begin
                  state_in = S_GROW_ADD;
               end
            end
         end

         S_GROW_ADD: begin
            unit_req.add_a = heap_top_ff;
            unit_req.add_b = want_ff;
            end_in         = unit_rsp.sum;
            state_in       = S_GROW_CHK;
         end

         S_GROW_CHK: begin
            unit_req.add_a = heap_top_ff;
            unit_req.cmp_a = {2'b00, heap_limit};
            unit_req.cmp_b = end_ff;
            if (grow_ok) begin
               tbl_wr_en   = 1'b1;
               tbl_wr_addr = count_ff[IDX_W-1:0];
               tbl_wr_data = '{blk_start: heap_top_ff, blk_size: want_ff, blk_free: 1'b0};
               count_in    = count_ff + CNT_W'(1);
               heap_top_in = end_ff[DATA_W-1:0];
               res_in      = '{status: ST_DONE, index: cnt_wide[IDX_OUT_W-1:0],
                               addr: unit_rsp.sum[DATA_W-1:0], size: want_ff};
            end else begin
               res_in = RESULT_NOMEM;
            end
            state_in = S_DONE;
         end

         S_FREE: begin
            unit_req.add_a = tbl_rd_data.blk_start;
            res_in = '{status: ST_DONE, index: idx_wide[IDX_OUT_W-1:0],
                       addr: unit_rsp.sum[DATA_W-1:0], size: tbl_rd_data.blk_size};
            if ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff) begin
               // top block: pop it and pull the heap top back
               heap_top_in = tbl_rd_data.blk_start;
               count_in    = CNT_W'(idx_ff);
            end else begin
               tbl_wr_en   = 1'b1;
               tbl_wr_addr = idx_ff;
               tbl_wr_data = '{blk_start: tbl_rd_data.blk_start,
                               blk_size: tbl_rd_data.blk_size, blk_free: 1'b1};
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         heap_top_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         heap_top_ff <= heap_top_in;
         rd_vld_ff   <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff   <= scan_in;
      rd_idx_ff <= rd_idx_in;
      end_ff    <= end_in;
      want_ff   <= want_in;
      idx_ff    <= idx_in;
      res_ff    <= res_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BLOCKS))
      else $error("block count above table depth");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("accepted item did not start work");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      tbl_wr_en |-> (state_ff == S_SCAN || state_ff == S_GROW_CHK || state_ff == S_FREE))
      else $error("table write outside scan, grow or free");

   a_grow_top: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GROW_CHK && grow_ok) |=> (heap_top_ff == $past(end_ff[DATA_W-1:0])))
      else $error("heap top not advanced after growth");

endmodule

`default_nettype wire

/* hdl/first_fit_heap_allocator.sv */
// first-fit heap allocator top level: limit register, result register, sequencer
// depends on ffha_pkg and ffha_seq (which holds ffha_unit and ffha_table)
// throughput: one item at a time; the scan reads one table entry per cycle
//   through the single read port of the block table, up to MAX_BLOCKS reads
// reset: synchronous, empties the table (entry count and heap top to zero)
//   and sets heap_limit to 65536; table contents are not cleared
`default_nettype none

module first_fit_heap_allocator #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 16
) (
   input  wire                               clock,
   input  wire                               reset,
   // request channel
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire                               req_opcode,
   input  wire [ffha_pkg::DATA_W-1:0]        req_size,
   input  wire [ffha_pkg::IDX_OUT_W-1:0]     req_block_index,
   // response channel
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [ffha_pkg::STATUS_W-1:0]     rsp_status,
   output logic [ffha_pkg::IDX_OUT_W-1:0]    rsp_granted_index,
   output logic [ffha_pkg::DATA_W-1:0]       rsp_payload_address,
   output logic [ffha_pkg::DATA_W-1:0]       rsp_granted_size,
   // heap limit register write
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire [ffha_pkg::DATA_W-1:0]        csr_heap_limit
);
   import ffha_pkg::*;

   logic [DATA_W-1:0] heap_limit_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff;

   logic              res_valid;
   logic              res_take;
   result_type        res_data;

   // the limit register takes a write in any cycle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_limit_ff <= HEAP_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         heap_limit_ff <= csr_heap_limit;
      end
   end

   ffha_seq #(
      .MAX_BLOCKS  (MAX_BLOCKS),
      .HEADER_BYTES(HEADER_BYTES)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_size       (req_size),
      .req_block_index(req_block_index),
      .heap_limit     (heap_limit_ff),
      .res_valid      (res_valid),
      .res_take       (res_take),
      .res_data       (res_data)
   );

   // output register frees the sequencer while a result waits downstream
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload holds while stalled, loads only on a take
   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_data_ff.status;
   assign rsp_granted_index   = rsp_data_ff.index;
   assign rsp_payload_address = rsp_data_ff.addr;
   assign rsp_granted_size    = rsp_data_ff.size;

endmodule

`default_nettype wire

/* tb/sv/first_fit_heap_allocator_tb.sv */
// self-checking testbench of the first-fit heap allocator: directed and random item streams
// depends on ffha_pkg and the first_fit_heap_allocator rtl; predicts every response itself
`default_nettype none

module first_fit_heap_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ffha_pkg::*;

   localparam int MAX_BLOCKS    = 64;
   localparam int HDR_BYTES     = 16;
   // pause of wait_idle, longer than the longest growth scan
   localparam int SETTLE_CYCLES = 80;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // block ports, all inputs known from time zero
   logic                 req_valid       = 1'b0;
   logic                 req_stall;
   logic                 req_opcode      = OP_ALLOC;
   logic [DATA_W-1:0]    req_size        = '0;
   logic [IDX_OUT_W-1:0] req_block_index = '0;
   logic                 rsp_valid;
   logic                 rsp_stall       = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [IDX_OUT_W-1:0] rsp_granted_index;
   logic [DATA_W-1:0]    rsp_payload_address;
   logic [DATA_W-1:0]    rsp_granted_size;
   logic                 csr_valid       = 1'b0;
   logic                 csr_ready;
   logic [DATA_W-1:0]    csr_heap_limit  = '0;

   first_fit_heap_allocator #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .HEADER_BYTES (HDR_BYTES)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_size            (req_size),
      .req_block_index     (req_block_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_granted_index   (rsp_granted_index),
      .rsp_payload_address (rsp_payload_address),
      .rsp_granted_size    (rsp_granted_size),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_heap_limit      (csr_heap_limit)
   );

   // shadow copy of the block table, heap top and limit register
   logic [DATA_W-1:0] blk_start_m [MAX_BLOCKS];
   logic [DATA_W-1:0] blk_size_m  [MAX_BLOCKS];
   bit                blk_free_m  [MAX_BLOCKS];
   int unsigned       blk_count_m  = 0;
   logic [DATA_W-1:0] heap_top_m   = '0;
   logic [DATA_W-1:0] heap_limit_m = HEAP_LIMIT_RESET;

   // responses predicted for accepted items, oldest first
   result_type awaited_grants[$];

   int  error_count  = 0;
   int  item_count   = 0;
   int  result_count = 0;
   int  limit_writes = 0;
   int  nomem_seen   = 0;
   int  reuse_seen   = 0;
   // when set, that side runs with no idling at all
   bit  tx_calm      = 1'b0;
   bit  rx_calm      = 1'b0;
   int  stall_left   = 0;

   // apply one item to the shadow table and return the response it causes
   function automatic result_type apply_request(opcode_type op, logic [DATA_W-1:0] want,
                                                logic [IDX_OUT_W-1:0] idx);
      result_type  r;
      logic [SUM_W-1:0] top_end;
      int unsigned k;
      r = '{status: ST_INVALID, index: '0, addr: '0, size: '0};
      if (op == OP_ALLOC) begin
         // zero-byte request is rejected outright
         if (want == '0)
            return r;
         // first fit over the blocks in address order
         for (k = 0; k < blk_count_m; k++) begin
            if (blk_free_m[k] && blk_size_m[k] >= want) begin
               blk_free_m[k] = 1'b0;
               r.status = ST_REUSED;
               r.index  = k[IDX_OUT_W-1:0];
               r.addr   = blk_start_m[k] + HDR_BYTES;
               r.size   = blk_size_m[k];
               return r;
            end
         end
         // growth, checked without wrap against the limit and the table depth
         top_end = {2'b00, heap_top_m} + HDR_BYTES + want;
         if (top_end > {2'b00, heap_limit_m} || blk_count_m >= MAX_BLOCKS) begin
            r.status = ST_NOMEM;
            return r;
         end
         k = blk_count_m;
         blk_start_m[k] = heap_top_m;
         blk_size_m[k]  = want;
         blk_free_m[k]  = 1'b0;
         blk_count_m    = k + 1;
         heap_top_m     = top_end[DATA_W-1:0];
         r.status = ST_DONE;
         r.index  = k[IDX_OUT_W-1:0];
         r.addr   = blk_start_m[k] + HDR_BYTES;
         r.size   = want;
      end else begin
         if (idx >= blk_count_m)
            return r;
         r.status = ST_DONE;
         r.index  = idx;
         r.addr   = blk_start_m[idx] + HDR_BYTES;
         r.size   = blk_size_m[idx];
         // top block pops even when already free, lower ones just get marked
         if (idx + 1 == blk_count_m) begin
            heap_top_m  = blk_start_m[idx];
            blk_count_m = idx;
         end else begin
            blk_free_m[idx] = 1'b1;
         end
      end
      return r;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // request size: small sizes dominate, plus zero, exact fits and full-range values
   function automatic logic [DATA_W-1:0] pick_size();
      int r;
      int unsigned k;
      r = $urandom_range(0, 99);
      if (r < 4)
         return '0;
      if (r < 60)
         return $urandom_range(1, 64);
      if (r < 80)
         return $urandom_range(65, 2048);
      if (r < 88 && blk_count_m != 0) begin
         k = $urandom_range(0, blk_count_m - 1);
         if (blk_free_m[k])
            return blk_size_m[k];
         return $urandom_range(1, 64);
      end
      return $urandom;
   endfunction

   // free target: mostly a block in the table, often the top one, sometimes anything
   function automatic logic [IDX_OUT_W-1:0] pick_index();
      int r;
      r = $urandom_range(0, 99);
      if (blk_count_m != 0 && r < 70)
         return IDX_OUT_W'($urandom_range(0, blk_count_m - 1));
      if (blk_count_m != 0 && r < 80)
         return IDX_OUT_W'(blk_count_m - 1);
      return IDX_OUT_W'($urandom_range(0, MAX_BLOCKS - 1));
   endfunction

   // send one item; called at a clock edge, returns at the edge that accepted it
   task automatic send_req(input opcode_type op, input logic [DATA_W-1:0] want,
                           input logic [IDX_OUT_W-1:0] idx);
      int gap;
      gap = tx_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_size        <= want;
      req_block_index <= idx;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      awaited_grants.push_back(apply_request(op, want, idx));
      item_count++;
   endtask

   // sender pause until every predicted response has arrived and the block has settled
   task automatic wait_idle();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (awaited_grants.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write the heap limit register while the block is idle
   task automatic set_heap_limit(input logic [DATA_W-1:0] limit);
      wait_idle();
      csr_valid      <= 1'b1;
      csr_heap_limit <= limit;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      heap_limit_m = limit;
      limit_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // pop blocks from the top until the table is empty
   task automatic drain_table();
      while (blk_count_m != 0)
         send_req(OP_FREE, $urandom, IDX_OUT_W'(blk_count_m - 1));
   endtask

   // hand-picked sequence through reuse, marking, popping and the limit
   task automatic test_directed();
      send_req(OP_ALLOC, 32'd0, 6'd0);              // zero-byte allocate
      send_req(OP_FREE, 32'd0, 6'd0);               // free on an empty table
      send_req(OP_ALLOC, 32'd100, 6'd0);
      send_req(OP_ALLOC, 32'd1, 6'd63);
      send_req(OP_ALLOC, 32'd200, 6'd0);
      send_req(OP_ALLOC, 32'hFFFF_FFFF, 6'd0);      // largest size, no wrap
      send_req(OP_FREE, 32'hFFFF_FFFF, 6'd1);       // mark a lower block free
      send_req(OP_FREE, 32'd0, 6'd1);               // free it again, stays free
      send_req(OP_ALLOC, 32'd2, 6'd0);              // too big for the hole, grows
      send_req(OP_ALLOC, 32'd1, 6'd0);              // exact reuse of the hole
      send_req(OP_FREE, 32'd0, 6'd0);
      send_req(OP_ALLOC, 32'd50, 6'd0);             // reuse of a larger hole
      send_req(OP_FREE, 32'd0, 6'd63);              // index past the table
      send_req(OP_FREE, 32'd0, 6'd3);               // pop the top block
      send_req(OP_FREE, 32'd0, 6'd1);
      send_req(OP_FREE, 32'd0, 6'd2);               // pop, leaves a free block on top
      send_req(OP_FREE, 32'd0, 6'd1);               // pop of an already free top block
      // grow exactly to the limit, then one byte more
      send_req(OP_ALLOC, heap_limit_m - heap_top_m - HDR_BYTES, 6'd0);
      send_req(OP_ALLOC, 32'd1, 6'd0);
      send_req(OP_FREE, 32'd0, 6'd1);
      send_req(OP_FREE, 32'd0, 6'd0);
   endtask

   // fill every table slot, hit the table-full case, reuse a hole, empty it again
   task automatic test_table_full();
      set_heap_limit(32'hFFFF_FFFF);
      drain_table();
      while (blk_count_m < MAX_BLOCKS)
         send_req(OP_ALLOC, $urandom_range(1, 256), IDX_OUT_W'($urandom));
      send_req(OP_ALLOC, 32'd1, 6'd0);
      send_req(OP_FREE, 32'd0, 6'd10);
      send_req(OP_ALLOC, 32'd300, 6'd0);            // no hole fits, table full
      send_req(OP_ALLOC, 32'd1, 6'd0);              // fills the hole
      drain_table();
   endtask

   // limit register at zero, just below and at the smallest fit, and at its top
   task automatic test_limit_extremes();
      set_heap_limit(32'd0);
      send_req(OP_ALLOC, 32'd1, 6'd0);
      send_req(OP_ALLOC, 32'd0, 6'd0);
      send_req(OP_ALLOC, 32'hFFFF_FFFF, 6'd0);
      send_req(OP_FREE, 32'd0, 6'd0);
      set_heap_limit(HDR_BYTES);
      send_req(OP_ALLOC, 32'd1, 6'd0);
      set_heap_limit(HDR_BYTES + 1);
      send_req(OP_ALLOC, 32'd1, 6'd0);
      send_req(OP_ALLOC, 32'd1, 6'd0);
      send_req(OP_FREE, 32'd0, 6'd0);
      set_heap_limit(32'hFFFF_FFFF);
      // heap top lands on the very last byte offset
      send_req(OP_ALLOC, 32'hFFFF_FFFF - HDR_BYTES, 6'd0);
      send_req(OP_ALLOC, 32'd1, 6'd0);
      send_req(OP_ALLOC, 32'hFFFF_FFFF, 6'd0);
      drain_table();
   endtask

   // random mix of allocate and free under one limit, with a full pause halfway
   task automatic run_random_phase(input int count, input logic [DATA_W-1:0] limit);
      int n;
      set_heap_limit(limit);
      for (n = 0; n < count; n++) begin
         if (n == count / 2)
            wait_idle();
         if ($urandom_range(0, 99) < 55)
            send_req(OP_ALLOC, pick_size(), IDX_OUT_W'($urandom));
         else
            send_req(OP_FREE, $urandom, pick_index());
      end
   endtask

   task automatic test_random();
      tx_calm = 1'b0;
      rx_calm = 1'b0;
      run_random_phase(330, HEAP_LIMIT_RESET);
      // tight limit keeps the heap near full
      tx_calm = 1'b1;
      run_random_phase(330, 32'd4096);
      tx_calm = 1'b0;
      rx_calm = 1'b1;
      run_random_phase(330, 32'hFFFF_FFFF);
      tx_calm = 1'b1;
      run_random_phase(160, $urandom_range(256, 20000));
      tx_calm = 1'b0;
      rx_calm = 1'b0;
      run_random_phase(160, $urandom);
      drain_table();
   endtask

   // response side: random stall, each accepted item checked against the oldest prediction
   always @(posedge clock) begin : rsp_check
      result_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (awaited_grants.size() == 0) begin
               $error("response item with no prediction waiting");
               error_count++;
            end else begin
               want = awaited_grants.pop_front();
               if (want.status == ST_NOMEM)
                  nomem_seen++;
               if (want.status == ST_REUSED)
                  reuse_seen++;
               if (rsp_status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_granted_index !== want.index) begin
                  $error("granted_index expected %0d got %0d", want.index, rsp_granted_index);
                  error_count++;
               end
               if (rsp_payload_address !== want.addr) begin
                  $error("payload_address expected %0h got %0h", want.addr,
                         rsp_payload_address);
                  error_count++;
               end
               if (rsp_granted_size !== want.size) begin
                  $error("granted_size expected %0h got %0h", want.size, rsp_granted_size);
                  error_count++;
               end
            end
         end
         // stall runs of random length, none while the receiver is calm
         if (rx_calm) begin
            rsp_stall <= 1'b0;
         end else if (stall_left != 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else if ($urandom_range(0, 99) < 30) begin
            rsp_stall  <= 1'b1;
            stall_left <= pick_gap();
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // test sequence
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_table_full();
      test_limit_extremes();
      test_random();
      wait_idle();
      $display("covered %0d items and %0d responses under %0d heap limit settings",
               item_count, result_count, limit_writes);
      $display("  %0d block reuses and %0d out-of-memory refusals among them",
               reuse_seen, nomem_seen);
      if (error_count == 0)
         $display("first_fit_heap_allocator_tb: clean");
      else
         $display("first_fit_heap_allocator_tb: errors");
      $finish;
   end

   // watchdog far beyond the slowest correct run
   initial begin
      #(20_000_000);
      $display("first_fit_heap_allocator_tb: errors");
      $finish;
   end

endmodule

`default_nettype wire
